[hw/rtl/tlfc_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle light-facing classifier: shared types and constants
// Request and result payloads, vertex and edge formats, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tlfc_pkg;

    localparam int COORD_W      = 16;
    localparam int INDEX_W      = 12;
    localparam int EDGE_W       = 17;
    localparam int PROD_W       = 34;
    localparam int CROSS_W      = 35;
    localparam int LIGHT_W      = 16;
    localparam int LPROD_W      = 51;
    localparam int DOT_W        = 53;
    localparam int THRESH_W     = 56;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 56;
    localparam int PIPE_LATENCY = 7;

    typedef enum logic {
        ACT_VERTEX_WRITE = 1'b0,
        ACT_TRIANGLE     = 1'b1
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LIGHT_X          = 3'd0,
        REG_LIGHT_Y          = 3'd1,
        REG_LIGHT_Z          = 3'd2,
        REG_FACING_THRESHOLD = 3'd3
    } cfg_reg_t;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [EDGE_W-1:0]   edge_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [CROSS_W-1:0]  cross_comp_t;
    typedef logic signed [LIGHT_W-1:0]  light_t;
    typedef logic signed [LPROD_W-1:0]  lprod_t;
    typedef logic signed [DOT_W-1:0]    dot_t;
    typedef logic signed [THRESH_W-1:0] thresh_t;
    typedef logic [INDEX_W-1:0]         vindex_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vertex_t;

    typedef struct packed {
        action_t action;
        vindex_t vertex_slot;
        coord_t  pos_x;
        coord_t  pos_y;
        coord_t  pos_z;
        vindex_t corner_a;
        vindex_t corner_b;
        vindex_t corner_c;
        logic    last_triangle;
    } item_t;

    typedef struct packed {
        logic faces_away;
        logic last_flag;
    } result_t;

    typedef struct packed {
        vertex_t v0;
        vertex_t v1;
        vertex_t v2;
        logic    last;
    } corners_t;

    typedef struct packed {
        cross_comp_t cx;
        cross_comp_t cy;
        cross_comp_t cz;
        logic        last;
    } cross_t;

    typedef struct packed {
        light_t  light_x;
        light_t  light_y;
        light_t  light_z;
        thresh_t threshold;
    } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/triangle_light_facing_classifier_unit.sv]
// ----------------------------------------------------------------------------
// Triangle light-facing classifier
// A triangle passes seven pipeline registers: store read, edge, product,
// cross, light product, sum, result. One request per cycle unless the result stalls.
// A vertex write updates the store at acceptance and gives no result.
// Reset clears every valid bit and the light and threshold registers; the
// vertex store holds unknown data until written.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_light_facing_classifier_unit #(
    parameter int VERTEX_DEPTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  tlfc_pkg::item_t                      item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output tlfc_pkg::result_t                    result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tlfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tlfc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tlfc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     store_ready;
    logic     corners_valid;
    logic     corners_ready;
    corners_t corners;
    logic     cross_valid;
    logic     cross_ready;
    cross_t   cross_prod;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LIGHT_X:          cfg_next.light_x   = cfg_data[LIGHT_W-1:0];
                REG_LIGHT_Y:          cfg_next.light_y   = cfg_data[LIGHT_W-1:0];
                REG_LIGHT_Z:          cfg_next.light_z   = cfg_data[LIGHT_W-1:0];
                REG_FACING_THRESHOLD: cfg_next.threshold = cfg_data[THRESH_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tlfc_vertex_store #(
        .VERTEX_DEPTH(VERTEX_DEPTH)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_valid),
        .in_ready (store_ready),
        .item     (item),
        .out_valid(corners_valid),
        .out_ready(corners_ready),
        .corners  (corners)
    );

    tlfc_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (corners_valid),
        .in_ready  (corners_ready),
        .corners   (corners),
        .out_valid (cross_valid),
        .out_ready (cross_ready),
        .cross_prod(cross_prod)
    );

    tlfc_light_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (cross_valid),
        .in_ready  (cross_ready),
        .cross_prod(cross_prod),
        .out_valid (result_valid),
        .out_ready (!result_stall),
        .result    (result)
    );

    assign item_stall = !store_ready;

endmodule

`default_nettype wire

[hw/rtl/tlfc_vertex_store.sv]
// ----------------------------------------------------------------------------
// Triangle light-facing classifier: vertex store
// Three copies of the vertex memory share every write so that the three
// corners of a triangle are read in the same cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfc_vertex_store #(
    parameter int VERTEX_DEPTH = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tlfc_pkg::item_t   item,
    output logic              out_valid,
    input  logic              out_ready,
    output tlfc_pkg::corners_t corners
);
    import tlfc_pkg::*;

    localparam int ADDR_W = $clog2(VERTEX_DEPTH);

    vertex_t mem_a [VERTEX_DEPTH];
    vertex_t mem_b [VERTEX_DEPTH];
    vertex_t mem_c [VERTEX_DEPTH];

    logic              accept;
    logic              wr_en;
    logic              rd_load;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_c;
    vertex_t           wr_vertex;
    vertex_t           rd_a_reg;
    vertex_t           rd_b_reg;
    vertex_t           rd_c_reg;
    logic              ok_a_reg;
    logic              ok_b_reg;
    logic              ok_c_reg;
    logic              last_reg;
    logic              valid_reg;
    logic              valid_next;

    function automatic logic in_range(input vindex_t idx);
        return int'(idx) < VERTEX_DEPTH;
    endfunction

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign wr_en    = accept && (item.action == ACT_VERTEX_WRITE)
                      && in_range(item.vertex_slot);
    assign rd_load  = accept && (item.action == ACT_TRIANGLE);

    assign wr_addr = ADDR_W'(item.vertex_slot);
    assign addr_a  = ADDR_W'(item.corner_a);
    assign addr_b  = ADDR_W'(item.corner_b);
    assign addr_c  = ADDR_W'(item.corner_c);

    always_comb
    begin
        wr_vertex.x = item.pos_x;
        wr_vertex.y = item.pos_y;
        wr_vertex.z = item.pos_z;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_vertex;
            mem_b[wr_addr] <= wr_vertex;
            mem_c[wr_addr] <= wr_vertex;
        end
        if (rd_load)
        begin
            rd_a_reg <= mem_a[addr_a];
            rd_b_reg <= mem_b[addr_b];
            rd_c_reg <= mem_c[addr_c];
            ok_a_reg <= in_range(item.corner_a);
            ok_b_reg <= in_range(item.corner_b);
            ok_c_reg <= in_range(item.corner_c);
            last_reg <= item.last_triangle;
        end
    end

    assign valid_next = rd_load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // A corner beyond the store depth reads as the origin.
    always_comb
    begin
        corners.v0   = ok_a_reg ? rd_a_reg : '0;
        corners.v1   = ok_b_reg ? rd_b_reg : '0;
        corners.v2   = ok_c_reg ? rd_c_reg : '0;
        corners.last = last_reg;
    end

    assign out_valid = valid_reg;

endmodule

`default_nettype wire

[hw/rtl/tlfc_cross.sv]
// ----------------------------------------------------------------------------
// Triangle light-facing classifier: edge and cross product pipeline
// Three stages: edge differences, partial products, cross product components.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfc_cross (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tlfc_pkg::corners_t corners,
    output logic               out_valid,
    input  logic               out_ready,
    output tlfc_pkg::cross_t   cross_prod
);
    import tlfc_pkg::*;

    logic  edge_ready;
    logic  prod_ready;
    logic  cross_ready;
    logic  edge_load;
    logic  prod_load;
    logic  cross_load;
    logic  edge_valid_reg;
    logic  edge_valid_next;
    logic  prod_valid_reg;
    logic  prod_valid_next;
    logic  cross_valid_reg;
    logic  cross_valid_next;

    edge_t e1x_reg;
    edge_t e1y_reg;
    edge_t e1z_reg;
    edge_t e2x_reg;
    edge_t e2y_reg;
    edge_t e2z_reg;
    logic  edge_last_reg;

    prod_t pxa_reg;
    prod_t pxb_reg;
    prod_t pya_reg;
    prod_t pyb_reg;
    prod_t pza_reg;
    prod_t pzb_reg;
    logic  prod_last_reg;

    cross_t cross_reg;

    assign cross_ready = !cross_valid_reg || out_ready;
    assign prod_ready  = !prod_valid_reg || cross_ready;
    assign edge_ready  = !edge_valid_reg || prod_ready;
    assign in_ready    = edge_ready;

    assign edge_load  = in_valid && edge_ready;
    assign prod_load  = edge_valid_reg && prod_ready;
    assign cross_load = prod_valid_reg && cross_ready;

    assign edge_valid_next  = edge_load || (edge_valid_reg && !prod_ready);
    assign prod_valid_next  = prod_load || (prod_valid_reg && !cross_ready);
    assign cross_valid_next = cross_load || (cross_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_valid_reg  <= 1'b0;
            prod_valid_reg  <= 1'b0;
            cross_valid_reg <= 1'b0;
        end
        else
        begin
            edge_valid_reg  <= edge_valid_next;
            prod_valid_reg  <= prod_valid_next;
            cross_valid_reg <= cross_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (edge_load)
        begin
            e1x_reg       <= EDGE_W'(corners.v1.x) - EDGE_W'(corners.v2.x);
            e1y_reg       <= EDGE_W'(corners.v1.y) - EDGE_W'(corners.v2.y);
            e1z_reg       <= EDGE_W'(corners.v1.z) - EDGE_W'(corners.v2.z);
            e2x_reg       <= EDGE_W'(corners.v1.x) - EDGE_W'(corners.v0.x);
            e2y_reg       <= EDGE_W'(corners.v1.y) - EDGE_W'(corners.v0.y);
            e2z_reg       <= EDGE_W'(corners.v1.z) - EDGE_W'(corners.v0.z);
            edge_last_reg <= corners.last;
        end
        if (prod_load)
        begin
            pxa_reg       <= PROD_W'(e1y_reg) * PROD_W'(e2z_reg);
            pxb_reg       <= PROD_W'(e1z_reg) * PROD_W'(e2y_reg);
            pya_reg       <= PROD_W'(e1z_reg) * PROD_W'(e2x_reg);
            pyb_reg       <= PROD_W'(e1x_reg) * PROD_W'(e2z_reg);
            pza_reg       <= PROD_W'(e1x_reg) * PROD_W'(e2y_reg);
            pzb_reg       <= PROD_W'(e1y_reg) * PROD_W'(e2x_reg);
            prod_last_reg <= edge_last_reg;
        end
        if (cross_load)
        begin
            cross_reg.cx   <= CROSS_W'(pxa_reg) - CROSS_W'(pxb_reg);
            cross_reg.cy   <= CROSS_W'(pya_reg) - CROSS_W'(pyb_reg);
            cross_reg.cz   <= CROSS_W'(pza_reg) - CROSS_W'(pzb_reg);
            cross_reg.last <= prod_last_reg;
        end
    end

    assign out_valid  = cross_valid_reg;
    assign cross_prod = cross_reg;

endmodule

`default_nettype wire

[hw/rtl/tlfc_light_dot.sv]
// ----------------------------------------------------------------------------
// Triangle light-facing classifier: light dot product and threshold compare
// Three stages: products with the light direction, their sum, the compare
// into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfc_light_dot (
    input  logic              clk,
    input  logic              rst_n,
    input  tlfc_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  tlfc_pkg::cross_t  cross_prod,
    output logic              out_valid,
    input  logic              out_ready,
    output tlfc_pkg::result_t result
);
    import tlfc_pkg::*;

    logic    lprod_ready;
    logic    sum_ready;
    logic    res_ready;
    logic    lprod_load;
    logic    sum_load;
    logic    res_load;
    logic    lprod_valid_reg;
    logic    lprod_valid_next;
    logic    sum_valid_reg;
    logic    sum_valid_next;
    logic    res_valid_reg;
    logic    res_valid_next;

    lprod_t  lx_reg;
    lprod_t  ly_reg;
    lprod_t  lz_reg;
    logic    lprod_last_reg;
    dot_t    dot_reg;
    logic    sum_last_reg;
    result_t result_reg;

    assign res_ready   = !res_valid_reg || out_ready;
    assign sum_ready   = !sum_valid_reg || res_ready;
    assign lprod_ready = !lprod_valid_reg || sum_ready;
    assign in_ready    = lprod_ready;

    assign lprod_load = in_valid && lprod_ready;
    assign sum_load   = lprod_valid_reg && sum_ready;
    assign res_load   = sum_valid_reg && res_ready;

    assign lprod_valid_next = lprod_load || (lprod_valid_reg && !sum_ready);
    assign sum_valid_next   = sum_load || (sum_valid_reg && !res_ready);
    assign res_valid_next   = res_load || (res_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lprod_valid_reg <= 1'b0;
            sum_valid_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            lprod_valid_reg <= lprod_valid_next;
            sum_valid_reg   <= sum_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lprod_load)
        begin
            lx_reg         <= LPROD_W'(cross_prod.cx) * LPROD_W'(cfg.light_x);
            ly_reg         <= LPROD_W'(cross_prod.cy) * LPROD_W'(cfg.light_y);
            lz_reg         <= LPROD_W'(cross_prod.cz) * LPROD_W'(cfg.light_z);
            lprod_last_reg <= cross_prod.last;
        end
        if (sum_load)
        begin
            dot_reg      <= DOT_W'(lx_reg) + DOT_W'(ly_reg) + DOT_W'(lz_reg);
            sum_last_reg <= lprod_last_reg;
        end
        if (res_load)
        begin
            result_reg.faces_away <= THRESH_W'(dot_reg) < cfg.threshold;
            result_reg.last_flag  <= sum_last_reg;
        end
    end

    assign out_valid = res_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

[hw/rtl/tlfc_checker.sv]
// ----------------------------------------------------------------------------
// Triangle light-facing classifier: port checker
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input tlfc_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input tlfc_pkg::result_t result
);
    import tlfc_pkg::*;

    logic [PIPE_LATENCY-1:0] tri_hist_reg;
    logic [PIPE_LATENCY-1:0] tri_hist_next;
    logic [PIPE_LATENCY-1:0] last_hist_reg;
    logic [PIPE_LATENCY-1:0] last_hist_next;
    logic [PIPE_LATENCY-2:0] flow_hist_reg;
    logic [PIPE_LATENCY-2:0] flow_hist_next;
    logic                    tri_accept;

    assign tri_accept     = item_valid && !item_stall && (item.action == ACT_TRIANGLE);
    assign tri_hist_next  = {tri_hist_reg[PIPE_LATENCY-2:0], tri_accept};
    assign last_hist_next = {last_hist_reg[PIPE_LATENCY-2:0], item.last_triangle};
    assign flow_hist_next = {flow_hist_reg[PIPE_LATENCY-3:0], !result_stall};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_hist_reg  <= '0;
            last_hist_reg <= '0;
            flow_hist_reg <= '0;
        end
        else
        begin
            tri_hist_reg  <= tri_hist_next;
            last_hist_reg <= last_hist_next;
            flow_hist_reg <= flow_hist_next;
        end
    end

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid during reset");

    a_stall_only_when_full: assert property (@(posedge clk)
        item_stall |-> (result_valid && result_stall))
        else $error("request stalled while the pipeline has room");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed or vanished");

    // A triangle with a free-running output arrives after the fixed latency.
    a_latency_and_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (tri_hist_reg[PIPE_LATENCY-1] && (&flow_hist_reg))
        |-> (result_valid && (result.last_flag == last_hist_reg[PIPE_LATENCY-1])))
        else $error("triangle result missing or last flag wrong");

endmodule

bind triangle_light_facing_classifier_unit tlfc_checker u_checker (.*);

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle light-facing classifier testbench
// Writes vertices into the store, sends triangle requests that only name written
// entries, and checks every facing flag and last-triangle echo against an
// exact fixed-point prediction, across several light and threshold settings.
// ----------------------------------------------------------------------------
module tb;
    import tlfc_pkg::*;

    localparam int      CLK_HALF       = 6;
    localparam int      CYCLE_LIMIT    = 400000;
    localparam int      DEPTH          = 4096;
    localparam int      RANDOM_PHASES  = 9;
    localparam int      PHASE_REQUESTS = 170;
    localparam int      LONG_HOLD      = 400;
    localparam int      PHASE_LIGHT_MAX  = 1;
    localparam int      PHASE_ALL_AWAY   = 2;
    localparam int      PHASE_NONE_AWAY  = 3;
    localparam int      HOLD_PHASE       = 4;
    localparam int      PAUSE_PHASE      = 6;
    localparam coord_t  COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t  COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
    localparam light_t  LIGHT_MAX  = {1'b0, {(LIGHT_W-1){1'b1}}};
    localparam light_t  LIGHT_MIN  = {1'b1, {(LIGHT_W-1){1'b0}}};
    localparam thresh_t THRESH_MAX = {1'b0, {(THRESH_W-1){1'b1}}};
    localparam thresh_t THRESH_MIN = {1'b1, {(THRESH_W-1){1'b0}}};

    class facing_scoreboard;
        vertex_t vertices [DEPTH];
        light_t  light_x;
        light_t  light_y;
        light_t  light_z;
        thresh_t threshold;
        result_t expected_results [$];
        int      failures;

        function new();
            light_x   = '0;
            light_y   = '0;
            light_z   = '0;
            threshold = '0;
            failures  = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_LIGHT_X:          light_x   = data[LIGHT_W-1:0];
                REG_LIGHT_Y:          light_y   = data[LIGHT_W-1:0];
                REG_LIGHT_Z:          light_z   = data[LIGHT_W-1:0];
                REG_FACING_THRESHOLD: threshold = data[THRESH_W-1:0];
                default: ;
            endcase
        endfunction

        function logic classify(vertex_t v0, vertex_t v1, vertex_t v2);
            longint e1x, e1y, e1z, e2x, e2y, e2z;
            longint cx, cy, cz, dot;
            e1x = longint'(v1.x) - longint'(v2.x);
            e1y = longint'(v1.y) - longint'(v2.y);
            e1z = longint'(v1.z) - longint'(v2.z);
            e2x = longint'(v1.x) - longint'(v0.x);
            e2y = longint'(v1.y) - longint'(v0.y);
            e2z = longint'(v1.z) - longint'(v0.z);
            cx = e1y * e2z - e1z * e2y;
            cy = e1z * e2x - e1x * e2z;
            cz = e1x * e2y - e1y * e2x;
            dot = cx * longint'(light_x) + cy * longint'(light_y) + cz * longint'(light_z);
            return dot < longint'(threshold);
        endfunction

        function void note_request(item_t r);
            result_t res;
            if (r.action == ACT_VERTEX_WRITE)
            begin
                vertices[r.vertex_slot] = {r.pos_x, r.pos_y, r.pos_z};
            end
            else
            begin
                res.faces_away = classify(vertices[r.corner_a], vertices[r.corner_b],
                                          vertices[r.corner_c]);
                res.last_flag  = r.last_triangle;
                expected_results.push_back(res);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result %b arrived with no triangle pending", got);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (got.faces_away !== want.faces_away)
            begin
                $error("faces_away: expected %0b, got %0b", want.faces_away, got.faces_away);
                failures++;
            end
            if (got.last_flag !== want.last_flag)
            begin
                $error("last_flag: expected %0b, got %0b", want.last_flag, got.last_flag);
                failures++;
            end
        endfunction
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    facing_scoreboard sb;
    bit               offering     = 1'b0;
    bit               calm         = 1'b0;
    bit               hold_results = 1'b0;
    int unsigned      cycle_count  = 0;
    vindex_t          written_slots [$];
    bit               slot_written [DEPTH];

    triangle_light_facing_classifier_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && item_valid && !item_stall)
            sb.note_request(item);
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_register(cfg_index, cfg_data);
    end

    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            result_stall <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 7))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2, 3:    return coord_t'(int'($urandom_range(0, 511)) - 256);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic item_t vertex_write(vindex_t slot, coord_t x, coord_t y, coord_t z);
        item_t r;
        r.action        = ACT_VERTEX_WRITE;
        r.vertex_slot   = slot;
        r.pos_x         = x;
        r.pos_y         = y;
        r.pos_z         = z;
        r.corner_a      = vindex_t'($urandom);
        r.corner_b      = vindex_t'($urandom);
        r.corner_c      = vindex_t'($urandom);
        r.last_triangle = 1'($urandom);
        if (!slot_written[slot])
        begin
            slot_written[slot] = 1'b1;
            written_slots.push_back(slot);
        end
        return r;
    endfunction

    function automatic item_t triangle(vindex_t a, vindex_t b, vindex_t c, logic last);
        item_t r;
        r.action        = ACT_TRIANGLE;
        r.vertex_slot   = vindex_t'($urandom);
        r.pos_x         = coord_t'($urandom);
        r.pos_y         = coord_t'($urandom);
        r.pos_z         = coord_t'($urandom);
        r.corner_a      = a;
        r.corner_b      = b;
        r.corner_c      = c;
        r.last_triangle = last;
        return r;
    endfunction

    function automatic item_t random_request();
        vindex_t a, b, c;
        if (written_slots.size() < 3 || $urandom_range(0, 9) < 3)
            return vertex_write(vindex_t'($urandom_range(0, DEPTH - 1)), pick_coord(),
                                pick_coord(), pick_coord());
        a = written_slots[$urandom_range(0, written_slots.size() - 1)];
        b = written_slots[$urandom_range(0, written_slots.size() - 1)];
        c = written_slots[$urandom_range(0, written_slots.size() - 1)];
        case ($urandom_range(0, 11))
            0:       b = a;
            1:       c = b;
            2:       a = c;
            3:
            begin
                b = a;
                c = a;
            end
            default: ;
        endcase
        return triangle(a, b, c, 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] light_word(light_t value);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'({$urandom, $urandom});
        w[LIGHT_W-1:0] = value;
        return w;
    endfunction

    task automatic send_request(item_t r);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            if (offering)
            begin
                item_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        item       <= r;
        item_valid <= 1'b1;
        offering = 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
    endtask

    task automatic end_requests();
        if (offering)
        begin
            item_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic settle();
        @(posedge clk);
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 3) @(posedge clk);
    endtask

    task automatic program_register(logic [CFG_INDEX_W-1:0] index,
                                    logic [CFG_DATA_W-1:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic configure(int phase);
        light_t  lx, ly, lz;
        thresh_t thr;
        longint  raw;
        lx  = light_t'($urandom);
        ly  = light_t'($urandom);
        lz  = light_t'($urandom);
        raw = {$urandom, $urandom};
        thr = ($urandom_range(0, 3) == 0) ? '0 : thresh_t'(raw >>> $urandom_range(8, 62));
        case (phase)
            PHASE_LIGHT_MAX:
            begin
                lx  = LIGHT_MAX;
                ly  = LIGHT_MAX;
                lz  = LIGHT_MAX;
                thr = '0;
            end
            PHASE_ALL_AWAY:
            begin
                lx  = LIGHT_MIN;
                ly  = LIGHT_MIN;
                lz  = LIGHT_MIN;
                thr = THRESH_MAX;
            end
            PHASE_NONE_AWAY: thr = THRESH_MIN;
            default: ;
        endcase
        program_register(REG_LIGHT_X, light_word(lx));
        program_register(REG_LIGHT_Y, light_word(ly));
        program_register(REG_LIGHT_Z, light_word(lz));
        program_register(REG_FACING_THRESHOLD, thr);
        if (phase > PHASE_NONE_AWAY)
        begin
            for (int i = REG_FACING_THRESHOLD + 1; i < 2 ** CFG_INDEX_W; i++)
                program_register(CFG_INDEX_W'(i), CFG_DATA_W'({$urandom, $urandom}));
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(vertex_write(vindex_t'(0), COORD_MAX, COORD_MIN, COORD_MAX));
        send_request(vertex_write(vindex_t'(DEPTH - 1), COORD_MIN, COORD_MAX, COORD_MIN));
        send_request(vertex_write(vindex_t'(2), coord_t'(0), coord_t'(0), coord_t'(0)));
        send_request(vertex_write(vindex_t'(3), coord_t'(-1), coord_t'(1), COORD_MIN));
        send_request(vertex_write(vindex_t'(2048), coord_t'(256), coord_t'(-256),
                                  coord_t'(128)));
        send_request(triangle(vindex_t'(0), vindex_t'(DEPTH - 1), vindex_t'(2), 1'b0));
        send_request(triangle(vindex_t'(DEPTH - 1), vindex_t'(0), vindex_t'(3), 1'b1));
        send_request(triangle(vindex_t'(3), vindex_t'(2048), vindex_t'(0), 1'b0));
        send_request(triangle(vindex_t'(0), vindex_t'(0), vindex_t'(0), 1'b1));
        send_request(triangle(vindex_t'(2048), vindex_t'(2048), vindex_t'(DEPTH - 1), 1'b0));
        send_request(triangle(vindex_t'(DEPTH - 1), vindex_t'(3), vindex_t'(3), 1'b1));
        send_request(vertex_write(vindex_t'(0), COORD_MIN, COORD_MIN, COORD_MAX));
        send_request(triangle(vindex_t'(0), vindex_t'(DEPTH - 1), vindex_t'(2), 1'b0));
        send_request(triangle(vindex_t'(2), vindex_t'(0), vindex_t'(DEPTH - 1), 1'b1));

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase > 0)
                configure(phase);
            calm = (phase == RANDOM_PHASES - 1);
            if (phase == HOLD_PHASE)
                hold_results = 1'b1;
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if (phase == PAUSE_PHASE && n == PHASE_REQUESTS / 2)
                begin
                    end_requests();
                    settle();
                end
                send_request(random_request());
            end
            end_requests();
            settle();
        end

        if (sb.failures == 0 && sb.expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
